// ===== rtl/srcw_pkg.sv =====
// srcw_pkg: shared constants and helpers for the sectioned rational curve warp
// no dependencies
`timescale 1ns / 1ps
package srcw_pkg;
  localparam int unsigned ORDERS_DEF    = 5;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned NUM_GAINS     = 5;
  localparam int unsigned GAIN_W        = 16;
  localparam int unsigned GAIN_FRAC     = 14;
  localparam int unsigned MAG_W         = GAIN_FRAC + 1;
  localparam logic signed [GAIN_W-1:0] GAIN_ONE = 16'sd16384;

  localparam logic [GAIN_W-1:0] GAIN0_RST = 16'd16384;
  localparam logic [GAIN_W-1:0] GAIN1_RST = 16'd11469;
  localparam logic [GAIN_W-1:0] GAIN2_RST = 16'hECCD;
  localparam logic [GAIN_W-1:0] GAIN3_RST = 16'd0;
  localparam logic [GAIN_W-1:0] GAIN4_RST = 16'd0;

  localparam int unsigned ADDR_W = 5;

  // limit a raw gain to -1.0 .. +1.0
  function automatic logic signed [GAIN_W-1:0] sat_gain(input logic [GAIN_W-1:0] raw);
    logic signed [GAIN_W-1:0] g;
    g = signed'(raw);
    if (g > GAIN_ONE) begin
      return GAIN_ONE;
    end else if (g < -GAIN_ONE) begin
      return -GAIN_ONE;
    end
    return g;
  endfunction
endpackage

// ===== rtl/srcw_stage.sv =====
// srcw_stage: one warp stage, split, rational bend with a pipelined restoring divider,
// rejoin and divide by the section count; uses srcw_pkg
`timescale 1ns / 1ps
module srcw_stage import srcw_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned NSEC      = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [FRAC_BITS:0]   x_i,
  input  logic [GAIN_W-1:0]    gain_i,
  output logic                 valid_o,
  output logic [FRAC_BITS:0]   x_o
);
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned VW  = F + 1;
  localparam int unsigned QW  = F + 1;
  localparam int unsigned DW  = F + 16;
  localparam int unsigned NW  = 2 * F + 17;
  localparam int unsigned PW  = F + 3;
  localparam int unsigned SW  = PW - F;
  localparam int unsigned RS  = F + 8;
  localparam int unsigned MW  = F + 9;
  localparam int unsigned L   = QW + 5;
  localparam logic [MW-1:0] RECIP = MW'((64'd1 << RS) / NSEC);
  localparam logic [VW-1:0] ONE   = VW'(1) << F;
  localparam logic [PW-1:0] NS    = PW'(NSEC);
  localparam logic [PW-1:0] NHALF = PW'(NSEC / 2);
  localparam logic [DW-1:0] DBASE = DW'(1) << (GAIN_FRAC + F);

  logic [L-1:0] vld_q;

  // split stage
  logic [PW-1:0] t_w;
  logic signed [GAIN_W-1:0] gsat_w, gs_w;
  logic [SW-1:0] sec0_q;
  logic [F-1:0]  f0_q;
  logic          neg0_q;
  logic [MAG_W-1:0] a0_q;
  assign t_w    = PW'(x_i) * NS;
  assign gsat_w = sat_gain(gain_i);
  assign gs_w   = t_w[F] ? -gsat_w : gsat_w;

  // numerator and denominator
  logic [VW-1:0] b_w;
  logic [MAG_W+VW-1:0] p_w;
  logic [DW-1:0] den_w;
  logic [15:0]   c_w;
  logic [NW-1:0] num_w;
  assign b_w   = neg0_q ? VW'(f0_q) : ONE - VW'(f0_q);
  assign p_w   = (MAG_W+VW)'(a0_q) * (MAG_W+VW)'(b_w);
  assign den_w = DBASE + DW'(p_w);
  assign c_w   = 16'(GAIN_ONE) + (neg0_q ? 16'(a0_q) : 16'd0);
  assign num_w = ((NW'(f0_q) * NW'(c_w)) << F) + NW'(den_w >> 1);

  logic [NW-1:0] rem_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [SW-1:0] sec_q [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[L-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sec0_q   <= t_w[PW-1:F];
      f0_q     <= t_w[F-1:0];
      neg0_q   <= gs_w[GAIN_W-1];
      a0_q     <= gs_w[GAIN_W-1] ? MAG_W'(-gs_w) : MAG_W'(gs_w);
      rem_q[0] <= num_w;
      den_q[0] <= den_w;
      quo_q[0] <= '0;
      sec_q[0] <= sec0_q;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [NW-1:0] sh_w;
    logic          ge_w;
    assign sh_w = NW'(den_q[j]) << (QW - 1 - j);
    assign ge_w = rem_q[j] >= sh_w;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= ge_w ? rem_q[j] - sh_w : rem_q[j];
        den_q[j+1] <= den_q[j];
        quo_q[j+1] <= {quo_q[j][QW-2:0], ge_w};
        sec_q[j+1] <= sec_q[j];
      end
    end
  end

  // rejoin, then divide by the section count via reciprocal
  logic [PW-1:0] v_q, v2_q, q0_q;
  logic [PW+MW-1:0] prod_w;
  logic [PW-1:0] r_w, q_w;
  logic [VW-1:0] x_q;
  assign prod_w = (PW+MW)'(v_q) * (PW+MW)'(RECIP);
  assign r_w    = v2_q - q0_q * NS;
  assign q_w    = (r_w >= NS) ? q0_q + PW'(1) : q0_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q  <= (PW'(sec_q[QW]) << F) + PW'(quo_q[QW]) + NHALF;
      q0_q <= PW'(prod_w >> RS);
      v2_q <= v_q;
      x_q  <= (q_w > PW'(ONE)) ? ONE : VW'(q_w);
    end
  end

  assign valid_o = vld_q[L-1];
  assign x_o     = x_q;
endmodule

// ===== rtl/sectioned_rational_curve_warp_top.sv =====
// sectioned_rational_curve_warp_top: config registers and the chain of warp stages
// uses srcw_pkg and srcw_stage
//
//  channel   | dir | signals
//  s_axis    | in  | s_axis_tvalid_i, s_axis_tready_o, s_axis_tdata_i (level_in)
//  m_axis    | out | m_axis_tvalid_o, m_axis_tready_i, m_axis_tdata_o (level_out)
//  apb       | in  | psel/penable/pwrite/paddr/pwdata, prdata/pready: gain_0..gain_4
//
// one word per cycle while the output is not stalled; each stage holds a pipelined
// restoring divider that resolves one quotient bit per cycle
// reset clears valid bits and restores the gains
// a stall at the output freezes the whole pipeline, nothing is lost or repeated
`timescale 1ns / 1ps
module sectioned_rational_curve_warp_top import srcw_pkg::*; #(
  parameter int unsigned ORDERS    = ORDERS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  localparam int unsigned VW       = FRAC_BITS + 1,
  localparam int unsigned TW       = ((VW + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [TW-1:0]     s_axis_tdata_i,   // level_in
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [TW-1:0]     m_axis_tdata_o,   // level_out
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  localparam logic [VW-1:0] ONE = VW'(1) << FRAC_BITS;

  logic [GAIN_W-1:0] gain_q [NUM_GAINS];
  logic [2:0] idx_w;
  assign idx_w  = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q[0] <= GAIN0_RST;
      gain_q[1] <= GAIN1_RST;
      gain_q[2] <= GAIN2_RST;
      gain_q[3] <= GAIN3_RST;
      gain_q[4] <= GAIN4_RST;
    end else if (psel && penable && pwrite && (32'(idx_w) < NUM_GAINS)) begin
      gain_q[idx_w] <= pwdata[GAIN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (32'(idx_w) < NUM_GAINS) begin
      prdata = 32'(gain_q[idx_w]);
    end
  end

  logic en_w;
  logic          vld_w [ORDERS+1];
  logic [VW-1:0] x_w   [ORDERS+1];

  assign en_w            = m_axis_tready_i || !vld_w[ORDERS];
  assign s_axis_tready_o = en_w;
  assign vld_w[0]        = s_axis_tvalid_i;
  // saturate input above 1.0
  assign x_w[0] = (s_axis_tdata_i[VW-1:0] > ONE) ? ONE : s_axis_tdata_i[VW-1:0];

  for (genvar k = 0; k < ORDERS; k++) begin : g_stage
    srcw_stage #(.FRAC_BITS(FRAC_BITS), .NSEC(k + 1)) u_stage (
      .clk_i,
      .rst_ni,
      .en_i    (en_w),
      .valid_i (vld_w[k]),
      .x_i     (x_w[k]),
      .gain_i  (gain_q[k]),
      .valid_o (vld_w[k+1]),
      .x_o     (x_w[k+1])
    );
  end

  assign m_axis_tvalid_o = vld_w[ORDERS];
  assign m_axis_tdata_o  = TW'(x_w[ORDERS]);
endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for the sectioned rational curve warp top level
// depends on srcw_pkg and sectioned_rational_curve_warp_top
`timescale 1ns / 1ps
module tb;
  import srcw_pkg::*;

  localparam int unsigned VW      = 17;
  localparam int unsigned TW      = 24;
  localparam int unsigned NSTAGE  = 5;
  localparam longint unsigned ONE = 64'd65536;
  localparam int unsigned LATENCY = NSTAGE * (16 + 6);
  localparam int unsigned NUM_RAND = 1120;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [TW-1:0] s_axis_tdata_i = '0;   // level_in [16:0], zero fill above
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [TW-1:0] m_axis_tdata_o;        // level_out [16:0], zero fill above
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sectioned_rational_curve_warp_top u_top (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [GAIN_W-1:0] gain_shadow [NUM_GAINS];
  logic [VW-1:0] warp_expected [$];
  int unsigned mismatches = 0;
  longint unsigned cycle_count = 0;
  bit hold_off = 1'b0;
  bit done = 1'b0;

  function automatic longint signed gain_limit(logic [GAIN_W-1:0] raw);
    longint signed g;
    g = longint'(signed'(raw));
    if (g > 16384) g = 16384;
    if (g < -16384) g = -16384;
    return g;
  endfunction

  function automatic longint unsigned round_div(longint unsigned n, longint unsigned d);
    return (n + d / 2) / d;
  endfunction

  function automatic logic [VW-1:0] warp_level(logic [VW-1:0] level);
    longint unsigned x, t, sec, f, fb, h, den;
    longint signed g;
    x = (level > ONE) ? ONE : level;
    for (int k = 0; k < NSTAGE; k++) begin
      t = x * (k + 1);
      sec = t >> 16;
      f = t & (ONE - 1);
      g = gain_limit(gain_shadow[k]);
      if (sec[0]) g = -g;
      if (g >= 0) begin
        den = longint'(g) * (ONE - f) + 16384 * ONE;
        fb = round_div(f * 16384 * ONE, den);
      end else begin
        h = -g;
        den = 16384 * ONE + h * f;
        fb = round_div(f * (16384 + h) * ONE, den);
      end
      x = round_div(sec * ONE + fb, k + 1);
      if (x > ONE) x = ONE;
    end
    return x[VW-1:0];
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // output stall pattern, with a forced long hold-off
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready_i <= 1'b0;
    else if ($urandom_range(0, 99) < 5) m_axis_tready_i <= 1'b0;
    else if ($urandom_range(0, 99) < 70) m_axis_tready_i <= 1'b1;
  end

  always @(posedge clk_i) begin
    logic [VW-1:0] exp_level;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (warp_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word level_out=%0d", m_axis_tdata_o[VW-1:0]);
      end else begin
        exp_level = warp_expected.pop_front();
        if (m_axis_tdata_o[VW-1:0] !== exp_level) begin
          mismatches++;
          if (mismatches <= 10)
            $display("level_out mismatch: expected %0d got %0d", exp_level,
                     m_axis_tdata_o[VW-1:0]);
        end
      end
    end
  end

  // valid stays high between back to back words; drain drops it
  task automatic send_level(logic [VW-1:0] level);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= TW'(level);
    do @(posedge clk_i); while (!s_axis_tready_o);
    warp_expected.push_back(warp_level(level));
  endtask

  task automatic write_gain(int idx, logic [GAIN_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_W'(4 * idx); pwdata <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx < NUM_GAINS) gain_shadow[idx] = value;
  endtask

  task automatic drain;
    s_axis_tvalid_i <= 1'b0;
    while (warp_expected.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 16'd16384;
      1: return 16'hC000;
      2: return 16'd0;
      3: return 16'($urandom);
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic logic [VW-1:0] pick_level();
    case ($urandom_range(0, 9))
      0: return 17'd65536;
      1: return 17'($urandom_range(65537, 131071));
      2: return 17'($urandom_range(0, 8));
      default: return 17'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic test_directed;
    logic [VW-1:0] lv [12] = '{17'd0, 17'd1, 17'd32768, 17'd65535, 17'd65536,
                               17'd65537, 17'h1FFFF, 17'h15555, 17'h0AAAA,
                               17'd21845, 17'd43690, 17'd16384};
    foreach (lv[i]) send_level(lv[i]);
    drain();
  endtask

  task automatic test_gain_extremes;
    logic [GAIN_W-1:0] gs [6] = '{16'd16384, 16'hC000, 16'd0, 16'h7FFF, 16'h8000, 16'd1};
    foreach (gs[j]) begin
      for (int i = 0; i < NUM_GAINS; i++) write_gain(i, gs[(j + i) % 6]);
      write_gain(NUM_GAINS, 16'h1234);   // beyond the last gain, ignored
      for (int n = 0; n < 8; n++) send_level(pick_level());
      drain();
    end
  endtask

  task automatic test_random;
    for (int p = 0; p < 7; p++) begin
      for (int i = 0; i < NUM_GAINS; i++) write_gain(i, pick_gain());
      for (int n = 0; n < NUM_RAND / 7; n++) send_level(pick_level());
      drain();
    end
  endtask

  task automatic test_backpressure;
    int waited;
    hold_off = 1'b1;
    fork
      begin
        waited = 0;
        while (waited < 600) begin
          @(posedge clk_i);
          waited++;
        end
        hold_off = 1'b0;
      end
      for (int n = 0; n < 200; n++) send_level(pick_level());
    join
    drain();
  endtask

  initial begin
    gain_shadow[0] = GAIN0_RST; gain_shadow[1] = GAIN1_RST;
    gain_shadow[2] = GAIN2_RST; gain_shadow[3] = GAIN3_RST;
    gain_shadow[4] = GAIN4_RST;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_gain_extremes();
    test_random();
    test_backpressure();
    if (mismatches == 0 && warp_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/srcw_pkg.sv
rtl/srcw_stage.sv
rtl/sectioned_rational_curve_warp_top.sv
bench/tb.sv
